### rtl/core/mcpe_pkg.sv
package mcpe_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WORD_W     = 32;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_SHIFT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_SHIFT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_SHIFT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_SHIFT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_WORD    = 3'd6;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EMIT = 1'b1;

  // output dimension cap, fits the 8-bit counter
  localparam logic [8:0] OUT_DIM_CAP = 9'd256;

  // what an emit carries from the read stage to the output register
  typedef struct packed {
    logic [7:0]        row;
    logic [7:0]        col;
    logic              last;
    logic              status;
    logic              from_store;
    logic [WORD_W-1:0] alt_word;
  } emit_meta_t;

endpackage

### rtl/core/mcpe_store.sv
module mcpe_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int W     = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [W-1:0]  wd,
  input  logic          re,
  input  logic [AW-1:0] ra,
  output logic [W-1:0]  rd
);

  logic [W-1:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[wa] <= wd;
    end
  end

  // read data holds while re is low, so a stalled read keeps its word
  always_ff @(posedge clk) begin
    if (re) begin
      rd <= ram[ra];
    end
  end

endmodule

### rtl/core/mcpe_seq.sv
module mcpe_seq #(
  parameter int MAX_DIM   = 64,
  parameter int ELEM_BITS = 32,
  parameter int AW        = 12
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [mcpe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mcpe_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             emit_go,
  input  logic                             load_go,
  input  logic [5:0]                       src_row,
  input  logic [5:0]                       src_col,
  output logic                             wr_en,
  output logic [AW-1:0]                    wr_addr,
  output logic [AW-1:0]                    rd_addr,
  output mcpe_pkg::emit_meta_t             meta
);

  localparam logic [mcpe_pkg::WORD_W-1:0] ELEM_MASK =
    (ELEM_BITS >= mcpe_pkg::WORD_W) ? {mcpe_pkg::WORD_W{1'b1}} :
    mcpe_pkg::WORD_W'((64'd1 << ELEM_BITS) - 64'd1);
  localparam logic [8:0] MAX_DIM_9 = 9'(MAX_DIM);

  logic [6:0]  src_rows;
  logic [6:0]  src_cols;
  logic [7:0]  left_shift;
  logic [7:0]  top_shift;
  logic [7:0]  right_shift;
  logic [7:0]  bottom_shift;
  logic [31:0] fill_word;
  logic [7:0]  emit_row;
  logic [7:0]  emit_col;
  logic [7:0]  emit_row_next;
  logic [7:0]  emit_col_next;

  logic [8:0]        rows;
  logic [8:0]        cols;
  logic signed [9:0] n_rows;
  logic signed [9:0] n_cols;
  logic              bad_shape;
  logic [8:0]        nr_cap;
  logic [8:0]        nc_cap;
  logic [7:0]        cur_row;
  logic [7:0]        cur_col;
  logic signed [9:0] si;
  logic signed [9:0] sj;
  logic              in_src;
  logic              is_last;

  always_comb begin
    rows = ({2'b00, src_rows} > MAX_DIM_9) ? MAX_DIM_9 : {2'b00, src_rows};
    cols = ({2'b00, src_cols} > MAX_DIM_9) ? MAX_DIM_9 : {2'b00, src_cols};
    n_rows = $signed({1'b0, rows}) - 10'($signed(top_shift))
             + 10'($signed(bottom_shift));
    n_cols = $signed({1'b0, cols}) - 10'($signed(left_shift))
             + 10'($signed(right_shift));
    bad_shape = (n_rows <= 10'sd0) || (n_cols <= 10'sd0);
    nr_cap = (n_rows > $signed({1'b0, mcpe_pkg::OUT_DIM_CAP})) ?
             mcpe_pkg::OUT_DIM_CAP : n_rows[8:0];
    nc_cap = (n_cols > $signed({1'b0, mcpe_pkg::OUT_DIM_CAP})) ?
             mcpe_pkg::OUT_DIM_CAP : n_cols[8:0];

    // restart when a shape change left the counter outside
    if (({1'b0, emit_row} >= nr_cap) || ({1'b0, emit_col} >= nc_cap)) begin
      cur_row = '0;
      cur_col = '0;
    end else begin
      cur_row = emit_row;
      cur_col = emit_col;
    end

    si = 10'($signed(top_shift)) + $signed({2'b00, cur_row});
    sj = 10'($signed(left_shift)) + $signed({2'b00, cur_col});
    in_src = (si >= 10'sd0) && (si < $signed({1'b0, rows})) &&
             (sj >= 10'sd0) && (sj < $signed({1'b0, cols}));
    is_last = ({1'b0, cur_row} == nr_cap - 9'd1) && ({1'b0, cur_col} == nc_cap - 9'd1);

    if (bad_shape || is_last) begin
      emit_row_next = '0;
      emit_col_next = '0;
    end else if ({1'b0, cur_col} + 9'd1 >= nc_cap) begin
      emit_row_next = cur_row + 8'd1;
      emit_col_next = '0;
    end else begin
      emit_row_next = cur_row;
      emit_col_next = cur_col + 8'd1;
    end

    rd_addr = AW'(si) * AW'(MAX_DIM) + AW'(sj);
    wr_addr = AW'(src_row) * AW'(MAX_DIM) + AW'(src_col);
    wr_en   = load_go && ({3'b000, src_row} < MAX_DIM_9) &&
              ({3'b000, src_col} < MAX_DIM_9);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_rows     <= 7'd1;
      src_cols     <= 7'd1;
      left_shift   <= '0;
      top_shift    <= '0;
      right_shift  <= '0;
      bottom_shift <= '0;
      fill_word    <= '0;
      emit_row     <= '0;
      emit_col     <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          mcpe_pkg::REG_SRC_ROWS:     src_rows     <= cfg_data[6:0];
          mcpe_pkg::REG_SRC_COLS:     src_cols     <= cfg_data[6:0];
          mcpe_pkg::REG_LEFT_SHIFT:   left_shift   <= cfg_data[7:0];
          mcpe_pkg::REG_TOP_SHIFT:    top_shift    <= cfg_data[7:0];
          mcpe_pkg::REG_RIGHT_SHIFT:  right_shift  <= cfg_data[7:0];
          mcpe_pkg::REG_BOTTOM_SHIFT: bottom_shift <= cfg_data[7:0];
          mcpe_pkg::REG_FILL_WORD:    fill_word    <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (emit_go) begin
        emit_row <= emit_row_next;
        emit_col <= emit_col_next;
      end
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (emit_go) begin
      if (bad_shape) begin
        meta.row        <= '0;
        meta.col        <= '0;
        meta.last       <= 1'b0;
        meta.status     <= 1'b1;
        meta.from_store <= 1'b0;
        meta.alt_word   <= '0;
      end else begin
        meta.row        <= cur_row;
        meta.col        <= cur_col;
        meta.last       <= is_last;
        meta.status     <= 1'b0;
        meta.from_store <= in_src;
        meta.alt_word   <= fill_word & ELEM_MASK;
      end
    end
  end

endmodule

### rtl/core/matrix_crop_pad_engine_top.sv
// emit path: an emit word is registered in the store read stage, then in the
//   output register once that is free (out_valid low or out_ready high)
// throughput: one word per cycle, loads and emits alike, while the output
//   takes words; set by the single store read port and the emit counter step
// reset: rst is synchronous, active high; clears the counter, the config and
//   valid registers to their defaults, the source store keeps its contents
module matrix_crop_pad_engine_top #(
  parameter int MAX_DIM   = 64,
  parameter int ELEM_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mcpe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mcpe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            action,
  input  logic [5:0]                      src_row,
  input  logic [5:0]                      src_col,
  input  logic [31:0]                     element,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [31:0]                     value,
  output logic [7:0]                      out_row,
  output logic [7:0]                      out_col,
  output logic                            last,
  output logic                            status
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);

  logic                 s1_valid;
  logic                 out_free;
  logic                 s1_move;
  logic                 in_go;
  logic                 emit_go;
  logic                 load_go;
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [ELEM_BITS-1:0] wr_data;
  logic [ELEM_BITS-1:0] rd_data;
  logic [ELEM_BITS+31:0] wr_wide;
  logic [ELEM_BITS+31:0] rd_wide;
  mcpe_pkg::emit_meta_t meta;

  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;
  // a read in flight that cannot move on blocks the input
  assign in_ready = !s1_valid || out_free;
  assign in_go    = in_valid && in_ready;
  assign emit_go  = in_go && (action == mcpe_pkg::ACT_EMIT);
  assign load_go  = in_go && (action == mcpe_pkg::ACT_LOAD);

  assign wr_wide = {{ELEM_BITS{1'b0}}, element};
  assign wr_data = wr_wide[ELEM_BITS-1:0];
  assign rd_wide = {32'b0, rd_data};

  mcpe_seq #(
    .MAX_DIM   (MAX_DIM),
    .ELEM_BITS (ELEM_BITS),
    .AW        (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .emit_go   (emit_go),
    .load_go   (load_go),
    .src_row   (src_row),
    .src_col   (src_col),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .meta      (meta)
  );

  mcpe_store #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .W     (ELEM_BITS)
  ) u_store (
    .clk (clk),
    .we  (wr_en),
    .wa  (wr_addr),
    .wd  (wr_data),
    .re  (emit_go),
    .ra  (rd_addr),
    .rd  (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      value   <= meta.from_store ? rd_wide[31:0] : meta.alt_word;
      out_row <= meta.row;
      out_col <= meta.col;
      last    <= meta.last;
      status  <= meta.status;
    end
  end

endmodule
